@@ hdl/pap_pkg.sv @@
// Shared types, register indexes and saturation helper for the particle axis pusher.
package pap_pkg;

	// Update modes
	localparam logic [1:0] MODE_DRIFT  = 2'd0;
	localparam logic [1:0] MODE_SSPRK  = 2'd1;
	localparam logic [1:0] MODE_KDK    = 2'd2;

	// Coordinate axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CURRENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SAVED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED_STEP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STAGE_ONE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MULTI_DIM      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_THREE_DIM      = 3'd7;

	typedef struct packed {
		logic [1:0]         axis;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic signed [31:0] saved_position;
		logic signed [31:0] saved_velocity;
		logic signed [31:0] acceleration;
		logic               last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_position;
		logic signed [31:0] new_velocity;
		logic signed [31:0] new_saved_position;
		logic signed [31:0] new_saved_velocity;
		logic               overflow;
		logic               last_out;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          value;
	} cfg_write_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	// Clip a wide signed value to 32 bits and flag clipping
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.ovf = 1'b1;
			r.val = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r.ovf = 1'b1;
			r.val = 32'sh80000000;
		end else begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/pap_stream_if.sv @@
// Valid/ready channel carrying one payload per transaction.
interface pap_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/particle_axis_pusher.sv @@
// Seven register stages lie between an input transaction and result valid.
// Throughput: one item per cycle; each stage holds while the stage after it is full
// and stalled, so an item enters whenever stage one is empty or moving.
// The KDK position update multiplies by the saturated new velocity, which sets depth.
// Reset clears stage valid bits and restores register defaults (stage one set).
// Configuration writes are taken every cycle.
module particle_axis_pusher import pap_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input logic           clk,
	input logic           arst_n,
	pap_stream_if.sink    items,
	pap_stream_if.source  results,
	pap_stream_if.sink    cfg
);

	// Rounded product and sum widths
	localparam int unsigned RW = 64 - FRAC_BITS;
	localparam int unsigned SW = RW + 2;

	typedef struct packed {
		logic [1:0]         axis;
		logic signed [31:0] x;
		logic signed [31:0] v;
		logic signed [31:0] x0;
		logic signed [31:0] v0;
		logic signed [31:0] a;
		logic               last;
		logic               ovf;
	} pipe_t;

	// Round-half-up of p / 2^FRAC_BITS, or / 2^(FRAC_BITS+1) when half is set
	function automatic logic signed [RW-1:0] round_shift(input logic signed [63:0] p,
		input logic half);
		logic signed [63:0] t;
		if (half)
			t = (p + (64'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
		else
			t = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return t[RW-1:0];
	endfunction

	// Configuration registers
	logic [1:0]         mode_q;
	logic [30:0]        time_step_q;
	logic signed [31:0] weight_current_q;
	logic signed [31:0] weight_saved_q;
	logic signed [31:0] weighted_step_q;
	logic               stage_one_q;
	logic               multi_dim_q;
	logic               three_dim_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_DRIFT;
			time_step_q      <= '0;
			weight_current_q <= '0;
			weight_saved_q   <= '0;
			weighted_step_q  <= '0;
			stage_one_q      <= 1'b1;
			multi_dim_q      <= 1'b0;
			three_dim_q      <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_MODE:           mode_q           <= cfg.data.value[1:0];
				CFG_TIME_STEP:      time_step_q      <= cfg.data.value[30:0];
				CFG_WEIGHT_CURRENT: weight_current_q <= cfg.data.value;
				CFG_WEIGHT_SAVED:   weight_saved_q   <= cfg.data.value;
				CFG_WEIGHTED_STEP:  weighted_step_q  <= cfg.data.value;
				CFG_STAGE_ONE:      stage_one_q      <= cfg.data.value[0];
				CFG_MULTI_DIM:      multi_dim_q      <= cfg.data.value[0];
				CFG_THREE_DIM:      three_dim_q      <= cfg.data.value[0];
				default: ;
			endcase
		end
	end

	logic is_ssprk, is_kdk, kdk_drift;
	logic signed [31:0] dt_op, step_op;

	assign is_ssprk  = (mode_q == MODE_SSPRK);
	assign is_kdk    = (mode_q == MODE_KDK);
	assign kdk_drift = is_kdk && stage_one_q;
	assign dt_op     = signed'({1'b0, time_step_q});
	assign step_op   = is_ssprk ? weighted_step_q : dt_op;

	// Stage valids and per-stage advance
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

	assign adv7 = !valid_s7 || results.ready;
	assign adv6 = !valid_s6 || adv7;
	assign adv5 = !valid_s5 || adv6;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign items.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= items.valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
			if (adv6) valid_s6 <= valid_s5;
			if (adv7) valid_s7 <= valid_s6;
		end
	end

	pipe_t pipe_s1, pipe_s2, pipe_s3, pipe_s4, pipe_s5, pipe_s6, pipe_s7;
	logic signed [63:0]   prod_s2 [6];
	logic signed [RW-1:0] rnd_s3  [6];
	logic signed [63:0]   prod_s5;
	logic signed [RW-1:0] rnd_s6;

	// Stage 1: capture, SSPRK first-stage copy into saved values
	always_ff @(posedge clk) begin
		if (adv1 && items.valid) begin
			pipe_s1.axis <= items.data.axis;
			pipe_s1.x    <= items.data.position;
			pipe_s1.v    <= items.data.velocity;
			pipe_s1.x0   <= (is_ssprk && stage_one_q) ?
				items.data.position : items.data.saved_position;
			pipe_s1.v0   <= (is_ssprk && stage_one_q) ?
				items.data.velocity : items.data.saved_velocity;
			pipe_s1.a    <= items.data.acceleration;
			pipe_s1.last <= items.data.last_in;
			pipe_s1.ovf  <= 1'b0;
		end
	end

	// Stage 2: products (drift uses slot 2, KDK kick uses slot 5)
	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			pipe_s2    <= pipe_s1;
			prod_s2[0] <= weight_current_q * pipe_s1.x;
			prod_s2[1] <= weight_saved_q * pipe_s1.x0;
			prod_s2[2] <= step_op * pipe_s1.v;
			prod_s2[3] <= weight_current_q * pipe_s1.v;
			prod_s2[4] <= weight_saved_q * pipe_s1.v0;
			prod_s2[5] <= step_op * pipe_s1.a;
		end
	end

	// Stage 3: rounding; the 0.5 factor of drift and kick folds into the shift
	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			pipe_s3 <= pipe_s2;
			for (int i = 0; i < 6; i++)
				rnd_s3[i] <= round_shift(prod_s2[i], !is_ssprk);
		end
	end

	// Stage 4: sums and saturation
	logic signed [SW-1:0] sum_x, sum_v;
	sat_t  sat_x, sat_v;
	logic  axis_en;
	pipe_t next_s4;

	always_comb begin
		axis_en = (pipe_s3.axis == AXIS_X) || (pipe_s3.axis == AXIS_Y && multi_dim_q) ||
			(pipe_s3.axis == AXIS_Z && three_dim_q);
		if (is_ssprk) begin
			sum_x = SW'(rnd_s3[0]) + SW'(rnd_s3[1]) + SW'(rnd_s3[2]);
			sum_v = SW'(rnd_s3[3]) + SW'(rnd_s3[4]) + SW'(rnd_s3[5]);
		end else begin
			sum_x = SW'(pipe_s3.x) + SW'(rnd_s3[2]);
			sum_v = SW'(pipe_s3.v) + SW'(rnd_s3[5]);
		end
		sat_x = sat32(64'(sum_x));
		sat_v = sat32(64'(sum_v));
		next_s4 = pipe_s3;
		case (mode_q)
			MODE_DRIFT: begin
				if (axis_en) begin
					next_s4.x   = sat_x.val;
					next_s4.ovf = sat_x.ovf;
				end
			end
			MODE_SSPRK: begin
				next_s4.x   = sat_x.val;
				next_s4.v   = sat_v.val;
				next_s4.ovf = sat_x.ovf || sat_v.ovf;
			end
			MODE_KDK: begin
				next_s4.v   = sat_v.val;
				next_s4.ovf = sat_v.ovf;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv4 && valid_s3)
			pipe_s4 <= next_s4;
	end

	// Stage 5: KDK drift product with the kicked velocity
	always_ff @(posedge clk) begin
		if (adv5 && valid_s4) begin
			pipe_s5 <= pipe_s4;
			prod_s5 <= dt_op * pipe_s4.v;
		end
	end

	// Stage 6: round the drift term
	always_ff @(posedge clk) begin
		if (adv6 && valid_s5) begin
			pipe_s6 <= pipe_s5;
			rnd_s6  <= round_shift(prod_s5, 1'b0);
		end
	end

	// Stage 7: KDK position drift, saved position takes the old position
	logic signed [RW:0] sum_d;
	sat_t  sat_d;
	pipe_t next_s7;

	always_comb begin
		sum_d   = (RW + 1)'(pipe_s6.x) + (RW + 1)'(rnd_s6);
		sat_d   = sat32(64'(sum_d));
		next_s7 = pipe_s6;
		if (kdk_drift) begin
			next_s7.x0  = pipe_s6.x;
			next_s7.x   = sat_d.val;
			next_s7.ovf = pipe_s6.ovf || sat_d.ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv7 && valid_s6)
			pipe_s7 <= next_s7;
	end

	// Result channel
	assign results.valid                   = valid_s7;
	assign results.data.new_position       = pipe_s7.x;
	assign results.data.new_velocity       = pipe_s7.v;
	assign results.data.new_saved_position = pipe_s7.x0;
	assign results.data.new_saved_velocity = pipe_s7.v0;
	assign results.data.overflow           = pipe_s7.ovf;
	assign results.data.last_out           = pipe_s7.last;

endmodule
